FILE: hw/rtl/fgpid_pkg.sv
// ----------------------------------------------------------------------------
// fgpid_pkg: shared types and constants
// Controller states, unit request types, register defaults and rule tables.
// ----------------------------------------------------------------------------
package fgpid_pkg;

   localparam int REG_COUNT   = 8;
   localparam int REG_W       = 16;
   localparam int REG_IDX_W   = 3;

   localparam int MUL_W       = 28;              // operand width of the serial multiplier
   localparam int MUL_CNT_W   = 5;
   localparam int DIV_N_W     = 48;              // dividend / quotient width
   localparam int DIV_D_W     = 20;              // divisor width
   localparam int DIV_CNT_W   = 6;

   localparam logic [19:0] MIN_DT_US      = 20'd1000;
   localparam logic [19:0] DEFAULT_DT_US  = 20'd20000;
   localparam logic [19:0] MICROS_PER_SEC = 20'd1000000;
   localparam logic [15:0] LOAD_HIGH_Q12  = 16'd4506;
   localparam logic signed [30:0] INTEGRAL_LIMIT = 31'sd6553600;

   // register indexes
   localparam logic [REG_IDX_W-1:0] REG_KP_BASE = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_KI_BASE = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_KD_BASE = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_TEMP    = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_SEASON  = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_MOIST   = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_SOIL    = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_LOAD    = 3'd7;

   localparam logic [REG_W-1:0] REG_RESET [REG_COUNT] = '{
      16'd4915, 16'd1024, 16'd328, 16'd4096, 16'd4096, 16'd4096, 16'd4096, 16'd4096
   };

   localparam logic [15:0] KD_ADJ_FAST = 16'd5325;
   localparam logic [15:0] ADJ_UNITY   = 16'd4096;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RATE_MUL,
      ST_RATE_DIV,
      ST_INT_MUL,
      ST_INT_DIV,
      ST_GAIN,
      ST_SUM,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic             start;
      logic [MUL_W-1:0] a;
      logic [MUL_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic               done;
      logic [2*MUL_W-1:0] product;
   } mul_rsp_type;

   typedef struct packed {
      logic               start;
      logic [DIV_N_W-1:0] dividend;
      logic [DIV_D_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [DIV_N_W-1:0] quotient;
   } div_rsp_type;

   // error class kind: 0 very low, 1 to 3 middle, 4 very high
   function automatic logic [15:0] kp_adj(input logic hi, input logic [2:0] ecls);
      logic [15:0] v;
      unique case (ecls)
         3'd0:    v = hi ? 16'd3932 : 16'd3277;
         3'd4:    v = hi ? 16'd7373 : 16'd6144;
         default: v = hi ? 16'd4915 : 16'd4096;
      endcase
      return v;
   endfunction

   function automatic logic [15:0] ki_adj(input logic hi, input logic [2:0] ecls);
      logic [15:0] v;
      unique case (ecls)
         3'd0:    v = hi ? 16'd5407 : 16'd4915;
         3'd4:    v = hi ? 16'd3604 : 16'd3277;
         default: v = hi ? 16'd4506 : 16'd4096;
      endcase
      return v;
   endfunction

endpackage

FILE: hw/rtl/fgpid_if.sv
// ----------------------------------------------------------------------------
// fgpid_if: request and response channels
// Valid/ready channels carrying the controller request and its response.
// ----------------------------------------------------------------------------
interface fgpid_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] target_value;
   logic [15:0] measured_value;
   logic [19:0] step_time_us;

   modport source (output valid, target_value, measured_value, step_time_us, input ready);
   modport sink (input valid, target_value, measured_value, step_time_us, output ready);
endinterface

interface fgpid_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] drive_value;
   logic [2:0] error_class;
   logic [2:0] rate_class;

   modport source (output valid, drive_value, error_class, rate_class, input ready);
   modport sink (input valid, drive_value, error_class, rate_class, output ready);
endinterface

FILE: hw/rtl/fgpid_mul.sv
// ----------------------------------------------------------------------------
// fgpid_mul: bit-serial multiplier
// Shift-add unsigned multiply, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module fgpid_mul
   import fgpid_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mul_req_type req,
   output mul_rsp_type rsp
);

   logic [MUL_W-1:0]     a_ff;
   logic [2*MUL_W-1:0]   prod_ff;
   logic [MUL_CNT_W-1:0] cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic [MUL_W:0]       partial;

   always_comb begin
      partial = {1'b0, prod_ff[2*MUL_W-1:MUL_W]} + (prod_ff[0] ? {1'b0, a_ff} : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (req.start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == MUL_CNT_W'(MUL_W-1));
         if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == MUL_CNT_W'(MUL_W-1)) busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         a_ff    <= req.a;
         prod_ff <= {{MUL_W{1'b0}}, req.b};
      end else if (busy_ff) begin
         prod_ff <= {partial, prod_ff[MUL_W-1:1]};
      end
   end

   assign rsp.done    = done_ff;
   assign rsp.product = prod_ff;

endmodule

FILE: hw/rtl/fgpid_div.sv
// ----------------------------------------------------------------------------
// fgpid_div: bit-serial divider
// Restoring unsigned division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fgpid_div
   import fgpid_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic [DIV_D_W-1:0]   divisor_ff;
   logic [DIV_D_W-1:0]   rem_ff;
   logic [DIV_N_W-1:0]   quo_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_D_W+1:0]   trial;
   logic                 borrow;

   always_comb begin
      trial  = {1'b0, rem_ff, quo_ff[DIV_N_W-1]} - {2'b00, divisor_ff};
      borrow = trial[DIV_D_W+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (req.start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == DIV_CNT_W'(DIV_N_W-1));
         if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_N_W-1)) busy_ff <= 1'b0;
         end
      end
   end

   // shift dividend bits out the top, quotient bits in the bottom
   always_ff @(posedge clock) begin
      if (req.start) begin
         divisor_ff <= req.divisor;
         rem_ff     <= '0;
         quo_ff     <= req.dividend;
      end else if (busy_ff) begin
         rem_ff <= borrow ? {rem_ff[DIV_D_W-2:0], quo_ff[DIV_N_W-1]} : trial[DIV_D_W-1:0];
         quo_ff <= {quo_ff[DIV_N_W-2:0], ~borrow};
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

FILE: hw/rtl/fuzzy_gain_scheduled_pid.sv
// ----------------------------------------------------------------------------
// fuzzy_gain_scheduled_pid: fuzzy gain-scheduled PID controller
// Classes error and error rate, schedules the gains and forms a saturated
// PID output, using one shared serial multiplier and one serial divider.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one sample (setpoint, measurement, time step); it is
//   taken when valid and ready are both high. rsp_chan returns one response
//   per request: drive value and the error and rate classes.
//   The csr_ port writes the eight gain and factor registers; write only
//   while no request is in progress.
//   One request is processed at a time: a new request is taken only in the
//   idle state. Each request makes twelve passes of the shared multiplier
//   (launch, one shift step per multiplier bit, completion) and two passes
//   of the divider, then loads the output register and returns to the idle
//   state, in which the next request is taken.
//   The response sits in an output register; while the receiver stalls, the
//   next request is still taken and computed, and then waits for the slot.
//   Synchronous reset loads the register defaults and clears the previous
//   error and the integral.
// ----------------------------------------------------------------------------
module fuzzy_gain_scheduled_pid
   import fgpid_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   fgpid_req_if.sink             req_chan,
   fgpid_rsp_if.source           rsp_chan,
   input  logic                  csr_write_en,
   input  logic [REG_IDX_W-1:0]  csr_index,
   input  logic [REG_W-1:0]      csr_write_data
);

   state_type state_ff, state_in;

   logic [REG_W-1:0] cfg_ff [REG_COUNT];

   logic [16:0] prev_ff;
   logic [23:0] integral_ff;
   logic [16:0] err_ff;
   logic [17:0] diff_ff;
   logic [19:0] dt_ff;
   logic [2:0]  ecls_ff;
   logic [2:0]  rcls_ff;
   logic [26:0] rmag_ff;
   logic [23:0] integ_ff;
   logic [24:0] kp_ff;
   logic [20:0] ki_ff;
   logic [20:0] kd_ff;
   logic [62:0] acc_ff;
   logic [1:0]  op_ff;
   logic [2:0]  gop_ff;
   logic        launched_ff;

   logic       rsp_valid_ff;
   logic [7:0] drive_ff;
   logic [2:0] rsp_ecls_ff;
   logic [2:0] rsp_rcls_ff;

   mul_req_type mreq;
   mul_rsp_type mrsp;
   div_req_type dreq;
   div_rsp_type drsp;

   logic        accept;
   logic        unit_done;
   logic        out_load;
   logic [16:0] err_c;
   logic [17:0] diff_c;
   logic [16:0] err_abs;
   logic [15:0] err_mag;
   logic [17:0] diff_abs;
   logic [16:0] diff_mag;
   logic [23:0] integ_abs;
   logic [2:0]  ecls_c;
   logic [2:0]  rcls_c;
   logic [26:0] rmag_c;
   logic [28:0] inc_c;
   logic signed [30:0] isum;
   logic signed [30:0] iclamp;
   logic        load_hi;
   logic [61:0] term;
   logic        term_neg;
   logic [7:0]  drive_c;

   fgpid_mul u_mul (.clock(clock), .reset(reset), .req(mreq), .rsp(mrsp));
   fgpid_div u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   // -------- front end and classes
   always_comb begin
      err_c    = {1'b0, req_chan.target_value} - {1'b0, req_chan.measured_value};
      diff_c   = {err_c[16], err_c} - {prev_ff[16], prev_ff};
      err_abs  = err_c[16] ? (~err_c + 1'b1) : err_c;
      err_mag  = err_abs[15:0];
      diff_abs = diff_ff[17] ? (~diff_ff + 1'b1) : diff_ff;
      diff_mag = diff_abs[16:0];
      if (err_mag < 16'd80)       ecls_c = 3'd0;
      else if (err_mag < 16'd240) ecls_c = 3'd1;
      else if (err_mag < 16'd480) ecls_c = 3'd2;
      else if (err_mag < 16'd800) ecls_c = 3'd3;
      else                        ecls_c = 3'd4;

      rmag_c = drsp.quotient[26:0];
      if (rmag_c < 27'd32)       rcls_c = 3'd0;
      else if (rmag_c < 27'd128) rcls_c = 3'd1;
      else if (rmag_c < 27'd320) rcls_c = 3'd2;
      else if (rmag_c < 27'd640) rcls_c = 3'd3;
      else                       rcls_c = 3'd4;

      inc_c = drsp.quotient[28:0];
      isum  = $signed({{7{integral_ff[23]}}, integral_ff}) +
              (err_ff[16] ? -$signed({2'b00, inc_c}) : $signed({2'b00, inc_c}));
      if (isum > INTEGRAL_LIMIT)       iclamp = INTEGRAL_LIMIT;
      else if (isum < -INTEGRAL_LIMIT) iclamp = -INTEGRAL_LIMIT;
      else                             iclamp = isum;

      integ_abs = integ_ff[23] ? (~integ_ff + 1'b1) : integ_ff;
      load_hi   = cfg_ff[REG_LOAD] >= LOAD_HIGH_Q12;

      case (op_ff)
         2'd1:    term = {18'd0, mrsp.product[43:0]};
         default: term = {mrsp.product[49:0], 12'd0};
      endcase
      case (op_ff)
         2'd0:    term_neg = err_ff[16];
         2'd1:    term_neg = integ_ff[23];
         default: term_neg = diff_ff[17];
      endcase

      if (acc_ff[62] || acc_ff == '0) drive_c = 8'd0;
      else if (acc_ff[61:36] != '0)   drive_c = 8'd255;
      else                            drive_c = acc_ff[35:28];
   end

   // -------- sequencer
   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in       = state_ff;
      mreq           = '0;
      dreq           = '0;
      unit_done      = 1'b0;
      accept         = 1'b0;
      out_load       = 1'b0;
      req_chan.ready = (state_ff == ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            accept = req_chan.valid;
            if (req_chan.valid) state_in = ST_RATE_MUL;
         end
         ST_RATE_MUL: begin
            mreq.start = ~launched_ff;
            mreq.a     = MUL_W'(diff_mag);
            mreq.b     = MUL_W'(MICROS_PER_SEC);
            unit_done  = launched_ff && mrsp.done;
            if (unit_done) state_in = ST_RATE_DIV;
         end
         ST_RATE_DIV: begin
            dreq.start    = ~launched_ff;
            dreq.dividend = mrsp.product[DIV_N_W-1:0];
            dreq.divisor  = dt_ff;
            unit_done     = launched_ff && drsp.done;
            if (unit_done) state_in = ST_INT_MUL;
         end
         ST_INT_MUL: begin
            mreq.start = ~launched_ff;
            mreq.a     = MUL_W'(err_ff[16] ? 17'(~err_ff + 1'b1) : err_ff);
            mreq.b     = MUL_W'(dt_ff);
            unit_done  = launched_ff && mrsp.done;
            if (unit_done) state_in = ST_INT_DIV;
         end
         ST_INT_DIV: begin
            dreq.start    = ~launched_ff;
            dreq.dividend = {mrsp.product[35:0], 12'd0};
            dreq.divisor  = MICROS_PER_SEC;
            unit_done     = launched_ff && drsp.done;
            if (unit_done) state_in = ST_GAIN;
         end
         ST_GAIN: begin
            mreq.start = ~launched_ff;
            case (gop_ff)
               3'd0: begin
                  mreq.a = MUL_W'(cfg_ff[REG_KP_BASE]);
                  mreq.b = MUL_W'(kp_adj(load_hi, ecls_ff));
               end
               3'd1: begin
                  mreq.a = MUL_W'(kp_ff);
                  mreq.b = MUL_W'(cfg_ff[REG_TEMP]);
               end
               3'd2: begin
                  mreq.a = MUL_W'(kp_ff);
                  mreq.b = MUL_W'(cfg_ff[REG_SEASON]);
               end
               3'd3: begin
                  mreq.a = MUL_W'(cfg_ff[REG_KI_BASE]);
                  mreq.b = MUL_W'(ki_adj(load_hi, ecls_ff));
               end
               3'd4: begin
                  mreq.a = MUL_W'(ki_ff);
                  mreq.b = MUL_W'(cfg_ff[REG_MOIST]);
               end
               3'd5: begin
                  mreq.a = MUL_W'(cfg_ff[REG_KD_BASE]);
                  mreq.b = MUL_W'((rcls_ff >= 3'd3) ? KD_ADJ_FAST : ADJ_UNITY);
               end
               default: begin
                  mreq.a = MUL_W'(kd_ff);
                  mreq.b = MUL_W'(cfg_ff[REG_SOIL]);
               end
            endcase
            unit_done = launched_ff && mrsp.done;
            if (unit_done && gop_ff == 3'd6) state_in = ST_SUM;
         end
         ST_SUM: begin
            mreq.start = ~launched_ff;
            case (op_ff)
               2'd0: begin
                  mreq.a = MUL_W'(kp_ff);
                  mreq.b = MUL_W'(err_ff[16] ? 17'(~err_ff + 1'b1) : err_ff);
               end
               2'd1: begin
                  mreq.a = MUL_W'(ki_ff);
                  mreq.b = MUL_W'(integ_abs);
               end
               default: begin
                  mreq.a = MUL_W'(kd_ff);
                  mreq.b = MUL_W'(rmag_ff);
               end
            endcase
            unit_done = launched_ff && mrsp.done;
            if (unit_done && op_ff == 2'd2) state_in = ST_OUT;
         end
         ST_OUT: begin
            // hold until the output slot is free
            out_load = ~rsp_valid_ff || rsp_chan.ready;
            if (out_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // -------- control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         launched_ff  <= 1'b0;
         gop_ff       <= '0;
         op_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         prev_ff      <= '0;
         integral_ff  <= '0;
         for (int i = 0; i < REG_COUNT; i++) cfg_ff[i] <= REG_RESET[i];
      end else begin
         if (csr_write_en) cfg_ff[csr_index] <= csr_write_data;
         if (unit_done)            launched_ff <= 1'b0;
         else if (mreq.start || dreq.start) launched_ff <= 1'b1;
         if (accept) begin
            gop_ff <= '0;
            op_ff  <= '0;
         end
         if (state_ff == ST_GAIN && unit_done) gop_ff <= gop_ff + 1'b1;
         if (state_ff == ST_SUM && unit_done)  op_ff  <= op_ff + 1'b1;
         if (state_ff == ST_INT_DIV && unit_done) integral_ff <= iclamp[23:0];
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
            prev_ff      <= err_ff;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // -------- datapath registers
   always_ff @(posedge clock) begin
      if (accept) begin
         err_ff  <= err_c;
         diff_ff <= diff_c;
         dt_ff   <= (req_chan.step_time_us <= MIN_DT_US) ? DEFAULT_DT_US
                                                          : req_chan.step_time_us;
         ecls_ff <= ecls_c;
         acc_ff  <= '0;
      end
      if (state_ff == ST_RATE_DIV && unit_done) begin
         rmag_ff <= rmag_c;
         rcls_ff <= rcls_c;
      end
      if (state_ff == ST_INT_DIV && unit_done) integ_ff <= iclamp[23:0];
      if (state_ff == ST_GAIN && unit_done) begin
         case (gop_ff)
            3'd0, 3'd1, 3'd2: kp_ff <= mrsp.product[36:12];
            3'd3, 3'd4:       ki_ff <= mrsp.product[32:12];
            default:          kd_ff <= mrsp.product[32:12];
         endcase
      end
      if (state_ff == ST_SUM && unit_done)
         acc_ff <= term_neg ? (acc_ff - {1'b0, term}) : (acc_ff + {1'b0, term});
      if (out_load) begin
         drive_ff    <= drive_c;
         rsp_ecls_ff <= ecls_ff;
         rsp_rcls_ff <= rcls_ff;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.drive_value = drive_ff;
   assign rsp_chan.error_class = rsp_ecls_ff;
   assign rsp_chan.rate_class  = rsp_rcls_ff;

endmodule
